// ===== rtl/core/clsr_pkg.sv =====
package clsr_pkg;

  // Input operation codes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_FLUSH = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_OFF   = 3'd3;
  localparam logic [2:0] OP_INIT  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_STROBE    = 2'd0;
  localparam logic [1:0] KIND_BACKLIGHT = 2'd1;
  localparam logic [1:0] KIND_ACK       = 2'd2;

  // Register select levels
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_BACKLIGHT = 2'd2;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Start points of the command scripts
  localparam logic [4:0] SCR_INIT = 5'd0;
  localparam logic [4:0] SCR_ON   = 5'd16;
  localparam logic [4:0] SCR_OFF  = 5'd19;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_FLUSH,
    CMD_CLEAR,
    CMD_OFF,
    CMD_INIT,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       hit;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] char_code;
  } job_t;

  typedef struct packed {
    logic [4:0] columns;
    logic [2:0] rows_used;
    logic       bl_on_level;
  } cfg_t;

  typedef struct packed {
    logic       bl;
    logic       bl_on;
    logic [3:0] nib;
    logic       fin;
  } step_t;

  // DDRAM address command for the start of each row
  function automatic logic [7:0] row_cmd(input logic [1:0] r);
    logic [7:0] v;
    unique case (r)
      2'd0: v = 8'h80;
      2'd1: v = 8'hC0;
      2'd2: v = 8'h94;
      2'd3: v = 8'hD4;
    endcase
    return v;
  endfunction

  // Power-up, display-on and display-off sequences, one result per entry
  function automatic step_t script_step(input logic [4:0] idx);
    step_t s;
    unique case (idx)
      5'd0:    s = '{bl: 1'b1, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd1:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h3, fin: 1'b0};
      5'd2:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h3, fin: 1'b0};
      5'd3:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h3, fin: 1'b0};
      5'd4:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h2, fin: 1'b0};
      5'd5:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h2, fin: 1'b0};
      5'd6:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h8, fin: 1'b0};
      5'd7:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd8:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'hC, fin: 1'b0};
      5'd9:    s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h1, fin: 1'b0};
      5'd10:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h4, fin: 1'b0};
      5'd11:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd12:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h1, fin: 1'b0};
      5'd13:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd14:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h6, fin: 1'b0};
      5'd15:   s = '{bl: 1'b1, bl_on: 1'b1, nib: 4'h0, fin: 1'b1};
      5'd16:   s = '{bl: 1'b1, bl_on: 1'b1, nib: 4'h0, fin: 1'b0};
      5'd17:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd18:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'hC, fin: 1'b1};
      5'd19:   s = '{bl: 1'b1, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd20:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b0};
      5'd21:   s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h8, fin: 1'b1};
      default: s = '{bl: 1'b0, bl_on: 1'b0, nib: 4'h0, fin: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/clsr_front.sv =====
module clsr_front
  import clsr_pkg::*;
#(
  parameter int MAX_COLUMNS = 20,
  parameter int MAX_ROWS    = 4
) (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [1:0] row,
  input  logic [4:0] col,
  input  logic [7:0] char_code,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic row_ok;
  logic col_ok;
  logic flush_ok;

  // Range checks against the panel geometry
  assign row_ok   = int'(row) < MAX_ROWS;
  assign col_ok   = (int'(col) < MAX_COLUMNS) && (col < cfg.columns);
  assign flush_ok = row_ok && ({1'b0, row} < cfg.rows_used);

  // Classify the item
  always_comb begin
    q_job.row       = row;
    q_job.col       = col;
    q_job.char_code = char_code;
    unique case (op)
      OP_WRITE: begin
        q_job.cmd = CMD_WRITE;
        q_job.hit = row_ok && col_ok;
      end
      OP_FLUSH: begin
        q_job.cmd = CMD_FLUSH;
        q_job.hit = flush_ok;
      end
      OP_CLEAR: begin
        q_job.cmd = CMD_CLEAR;
        q_job.hit = 1'b1;
      end
      OP_OFF: begin
        q_job.cmd = CMD_OFF;
        q_job.hit = 1'b1;
      end
      OP_INIT: begin
        q_job.cmd = CMD_INIT;
        q_job.hit = 1'b1;
      end
      default: begin
        q_job.cmd = CMD_NOP;
        q_job.hit = 1'b0;
      end
    endcase
  end

  // Accept while the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/core/clsr_queue.sv =====
module clsr_queue
  import clsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/clsr_back.sv =====
module clsr_back
  import clsr_pkg::*;
#(
  parameter int MAX_COLUMNS = 20,
  parameter int MAX_ROWS    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cols_upd,
  input  job_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic       backlight,
  output logic       last
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCRIPT,
    S_CMP_RD,
    S_CMP_CHK,
    S_ACK,
    S_ADDR_HI,
    S_ADDR_LO,
    S_RD,
    S_HI,
    S_LO
  } state_t;

  state_t            state;
  job_t              job;
  logic [4:0]        step;
  logic [COL_W-1:0]  c;
  logic [3:0]        row_sent_valid;
  logic              display_on;
  logic              backlight_state;

  logic [7:0]        text_mem [DEPTH];
  logic [7:0]        sent_mem [DEPTH];
  logic [DEPTH-1:0]  text_vld;
  logic [7:0]        text_q;
  logic              text_vq;
  logic [7:0]        sent_q;

  logic [COL_W-1:0]  eff_w;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] wr_a;
  logic [ADDR_W-1:0] rd_a;
  logic              txt_we;
  logic              rd_en;
  logic              snt_we;
  logic              clr_all;
  logic              emit_ok;
  logic [7:0]        chr;
  logic [7:0]        rcmd;
  logic              final_chr;
  step_t             cur_step;
  logic              step_level;

  // Effective row width
  always_comb begin
    if (int'(cfg.columns) > MAX_COLUMNS) begin
      eff_w = COL_W'(MAX_COLUMNS);
    end else begin
      eff_w = COL_W'(cfg.columns);
    end
  end

  assign emit_ok    = !out_valid || !out_stall;
  assign row_base   = ADDR_W'(int'(job.row) * MAX_COLUMNS);
  assign wr_a       = row_base + ADDR_W'(job.col);
  assign rd_a       = row_base + ADDR_W'(c);
  assign chr        = text_vq ? text_q : SPACE_CHAR;
  assign rcmd       = row_cmd(job.row);
  assign final_chr  = ((c + 1'b1) == eff_w);
  assign cur_step   = script_step(step);
  assign step_level = cur_step.bl_on ? cfg.bl_on_level : ~cfg.bl_on_level;
  assign q_pop      = (state == S_IDLE) && !q_empty;

  // Memory controls
  always_comb begin
    txt_we  = (state == S_EXEC) && (job.cmd == CMD_WRITE) && job.hit && emit_ok;
    clr_all = (state == S_EXEC) && (job.cmd == CMD_CLEAR);
    rd_en   = ((state == S_CMP_RD) && (c != eff_w)) || (state == S_RD);
    snt_we  = (state == S_HI) && emit_ok;
  end

  // Shadow text and last-sent copy
  always_ff @(posedge clk) begin
    if (txt_we) begin
      text_mem[wr_a] <= job.char_code;
    end
    if (snt_we) begin
      sent_mem[rd_a] <= chr;
    end
    if (rd_en) begin
      text_q  <= text_mem[rd_a];
      text_vq <= text_vld[rd_a];
      sent_q  <= sent_mem[rd_a];
    end
  end

  // Written marks; an unmarked cell reads as a space
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      text_vld <= '0;
    end else if (cols_upd) begin
      for (int e = 0; e < DEPTH; e++) begin
        if ((e % MAX_COLUMNS) >= int'(eff_w)) begin
          text_vld[e] <= 1'b0;
        end
      end
    end else if (txt_we) begin
      text_vld[wr_a] <= 1'b1;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      row_sent_valid  <= '0;
      display_on      <= 1'b0;
      backlight_state <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid <= 1'b0;
      end
      if (cols_upd) begin
        row_sent_valid <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (job.cmd)
            CMD_CLEAR: begin
              if (display_on) begin
                state <= S_ACK;
              end else begin
                display_on <= 1'b1;
                step       <= SCR_ON;
                state      <= S_SCRIPT;
              end
            end
            CMD_OFF: begin
              if (display_on) begin
                display_on <= 1'b0;
                step       <= SCR_OFF;
                state      <= S_SCRIPT;
              end else begin
                state <= S_ACK;
              end
            end
            CMD_INIT: begin
              display_on     <= 1'b1;
              row_sent_valid <= '0;
              step           <= SCR_INIT;
              state          <= S_SCRIPT;
            end
            CMD_FLUSH: begin
              c <= '0;
              if (!job.hit) begin
                state <= S_ACK;
              end else if (row_sent_valid[job.row]) begin
                state <= S_CMP_RD;
              end else begin
                state <= S_ADDR_HI;
              end
            end
            CMD_WRITE, CMD_NOP: begin
              if (emit_ok) begin
                out_valid  <= 1'b1;
                kind       <= KIND_ACK;
                reg_select <= RS_CMD;
                nibble     <= 4'h0;
                backlight  <= backlight_state;
                last       <= 1'b1;
                state      <= S_IDLE;
              end
            end
          endcase
        end
        S_SCRIPT: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            reg_select <= RS_CMD;
            last       <= cur_step.fin;
            if (cur_step.bl) begin
              backlight_state <= step_level;
              kind            <= KIND_BACKLIGHT;
              nibble          <= 4'h0;
              backlight       <= step_level;
            end else begin
              kind      <= KIND_STROBE;
              nibble    <= cur_step.nib;
              backlight <= backlight_state;
            end
            if (cur_step.fin) begin
              state <= S_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_CMP_RD: begin
          // Whole row matched the copy last sent
          if (c == eff_w) begin
            state <= S_ACK;
          end else begin
            state <= S_CMP_CHK;
          end
        end
        S_CMP_CHK: begin
          if (chr != sent_q) begin
            c     <= '0;
            state <= S_ADDR_HI;
          end else begin
            c     <= c + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_ACK: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            kind       <= KIND_ACK;
            reg_select <= RS_CMD;
            nibble     <= 4'h0;
            backlight  <= backlight_state;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_ADDR_HI: begin
          if (emit_ok) begin
            out_valid               <= 1'b1;
            kind                    <= KIND_STROBE;
            reg_select              <= RS_CMD;
            nibble                  <= rcmd[7:4];
            backlight               <= backlight_state;
            last                    <= 1'b0;
            row_sent_valid[job.row] <= 1'b1;
            state                   <= S_ADDR_LO;
          end
        end
        S_ADDR_LO: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            kind       <= KIND_STROBE;
            reg_select <= RS_CMD;
            nibble     <= rcmd[3:0];
            backlight  <= backlight_state;
            last       <= (eff_w == '0);
            state      <= (eff_w == '0) ? S_IDLE : S_RD;
          end
        end
        S_RD: begin
          state <= S_HI;
        end
        S_HI: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            kind       <= KIND_STROBE;
            reg_select <= RS_DATA;
            nibble     <= chr[7:4];
            backlight  <= backlight_state;
            last       <= 1'b0;
            state      <= S_LO;
          end
        end
        S_LO: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            kind       <= KIND_STROBE;
            reg_select <= RS_DATA;
            nibble     <= chr[3:0];
            backlight  <= backlight_state;
            last       <= final_chr;
            if (final_chr) begin
              state <= S_IDLE;
            end else begin
              c     <= c + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/char_lcd_shadow_refresh.sv =====
// Character LCD controller for a 4-bit HD44780-style bus with a shadow text
// buffer. Each input item is one operation (write char, flush row, clear,
// display off, init) and yields one or more result items: nibble strobes,
// backlight updates, or a single acknowledge; the final one carries last.
// Items are classified on entry and wait in a two-entry queue, so the input
// keeps accepting while the sequencer drains earlier work. The sequencer
// makes at most one result per cycle into an output register. A flush of a
// row that was sent before first compares it with the sent copy, one memory
// read and one compare per column; a flush that sends emits the address
// command and then, per column, a text read and two strobes. Result steps
// wait while the output is stalled. Configuration writes are expected only
// while the block is idle.
module char_lcd_shadow_refresh
  import clsr_pkg::*;
#(
  parameter int MAX_COLUMNS = 20,
  parameter int MAX_ROWS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [1:0]  row,
  input  logic [4:0]  col,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic        backlight,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic cols_upd;
  logic cfg_we;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  job_t q_job;
  job_t q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns     <= 5'd16;
      cfg.rows_used   <= 3'd2;
      cfg.bl_on_level <= 1'b1;
      cols_upd        <= 1'b0;
    end else begin
      cols_upd <= cfg_we && (paddr[3:2] == REG_COLUMNS);
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_COLUMNS:   cfg.columns     <= pwdata[4:0];
          REG_ROWS:      cfg.rows_used   <= pwdata[2:0];
          REG_BACKLIGHT: cfg.bl_on_level <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_COLUMNS:   prdata = {27'd0, cfg.columns};
      REG_ROWS:      prdata = {29'd0, cfg.rows_used};
      REG_BACKLIGHT: prdata = {31'd0, cfg.bl_on_level};
      default:       prdata = 32'd0;
    endcase
  end

  clsr_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .row      (row),
    .col      (col),
    .char_code(char_code),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  clsr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_job),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  clsr_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cols_upd  (cols_upd),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .reg_select(reg_select),
    .nibble    (nibble),
    .backlight (backlight),
    .last      (last)
  );

  // Only strobes carry bus data
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_STROBE) |-> (reg_select == RS_CMD) && (nibble == 4'h0))
    else $error("non-strobe result carries bus data");

  // An acknowledge always closes its item
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ACK) |-> last)
    else $error("acknowledge without last");

  // The closing backlight update of init turns the backlight on
  a_init_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_BACKLIGHT) && last |-> (backlight == cfg.bl_on_level))
    else $error("init ended with backlight off");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import clsr_pkg::*;

  localparam int PANEL_ROWS       = 4;
  localparam int PANEL_COLS       = 20;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 23;
  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 10;
  localparam int DRAIN_CYCLES     = 60;
  localparam int MAX_STALL_RUN    = 6;

  // Operation codes the block treats as no-ops
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] LCD_DISPLAY_OFF = 8'h08;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] ch;
  } lcd_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       rs;
    logic [3:0] nib;
    logic       bl;
    logic       last;
  } bus_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [1:0]  row = '0;
  logic [4:0]  col = '0;
  logic [7:0]  char_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic        reg_select;
  logic [3:0]  nibble;
  logic        backlight;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_shadow_refresh u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .row        (row),
    .col        (col),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .reg_select (reg_select),
    .nibble     (nibble),
    .backlight  (backlight),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Panel image kept alongside the block
  logic [7:0] shadow_text [PANEL_ROWS][PANEL_COLS];
  logic [7:0] panel_copy [PANEL_ROWS][PANEL_COLS];
  bit         row_synced [PANEL_ROWS];
  bit         disp_on;
  logic       bl_level;
  logic [4:0] cfg_columns;
  logic [2:0] cfg_rows;
  logic       cfg_bl_on;

  logic [7:0] ddram_base [PANEL_ROWS] = '{8'h80, 8'hC0, 8'h94, 8'hD4};
  logic [7:0] power_up_cmds [7] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h14, 8'h01, 8'h06};

  lcd_op_t pending_ops [$];
  bus_op_t expected_bus_ops [$];
  bus_op_t staged_op;
  bit      staged_valid;
  int      ops_queued;
  int      ops_taken;
  int      mismatches;

  function automatic int eff_width();
    return (cfg_columns > PANEL_COLS) ? PANEL_COLS : int'(cfg_columns);
  endfunction

  function automatic int eff_rows();
    return (cfg_rows > PANEL_ROWS) ? PANEL_ROWS : int'(cfg_rows);
  endfunction

  function automatic void reset_panel_model();
    for (int r = 0; r < PANEL_ROWS; r++) begin
      row_synced[r] = 1'b0;
      for (int c = 0; c < PANEL_COLS; c++) begin
        shadow_text[r][c] = SPACE_CHAR;
        panel_copy[r][c] = '0;
      end
    end
    disp_on = 1'b0;
    bl_level = 1'b0;
    cfg_columns = 5'd16;
    cfg_rows = 3'd2;
    cfg_bl_on = 1'b1;
    staged_valid = 1'b0;
  endfunction

  // Hold back the newest result so the final one of an item can be marked
  function automatic void emit(logic [1:0] k, logic rs, logic [3:0] nib);
    if (staged_valid) expected_bus_ops.push_back(staged_op);
    staged_op = '{kind: k, rs: rs, nib: nib, bl: bl_level, last: 1'b0};
    staged_valid = 1'b1;
  endfunction

  function automatic void emit_byte(logic rs, logic [7:0] value);
    emit(KIND_STROBE, rs, value[7:4]);
    emit(KIND_STROBE, rs, value[3:0]);
  endfunction

  function automatic void emit_backlight(logic level);
    bl_level = level;
    emit(KIND_BACKLIGHT, RS_CMD, 4'h0);
  endfunction

  function automatic void predict_lcd_ops(lcd_op_t f);
    int  width;
    int  c;
    bit  same;
    width = eff_width();
    case (f.op)
      OP_WRITE: begin
        if (f.col < width) shadow_text[f.row][f.col] = f.ch;
        emit(KIND_ACK, RS_CMD, 4'h0);
      end
      OP_FLUSH: begin
        if (f.row < eff_rows()) begin
          same = row_synced[f.row];
          for (c = 0; c < width; c++)
            if (panel_copy[f.row][c] !== shadow_text[f.row][c]) same = 1'b0;
          if (same) begin
            emit(KIND_ACK, RS_CMD, 4'h0);
          end else begin
            emit_byte(RS_CMD, ddram_base[f.row]);
            for (c = 0; c < width; c++) begin
              emit_byte(RS_DATA, shadow_text[f.row][c]);
              panel_copy[f.row][c] = shadow_text[f.row][c];
            end
            row_synced[f.row] = 1'b1;
          end
        end else begin
          emit(KIND_ACK, RS_CMD, 4'h0);
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < PANEL_ROWS; r++)
          for (c = 0; c < PANEL_COLS; c++) shadow_text[r][c] = SPACE_CHAR;
        if (!disp_on) begin
          emit_backlight(cfg_bl_on);
          disp_on = 1'b1;
          emit_byte(RS_CMD, LCD_DISPLAY_ON);
        end else begin
          emit(KIND_ACK, RS_CMD, 4'h0);
        end
      end
      OP_OFF: begin
        if (disp_on) begin
          emit_backlight(~cfg_bl_on);
          disp_on = 1'b0;
          emit_byte(RS_CMD, LCD_DISPLAY_OFF);
        end else begin
          emit(KIND_ACK, RS_CMD, 4'h0);
        end
      end
      OP_INIT: begin
        emit_backlight(~cfg_bl_on);
        for (c = 0; c < 7; c++) emit_byte(RS_CMD, power_up_cmds[c]);
        emit_backlight(cfg_bl_on);
        disp_on = 1'b1;
        for (int r = 0; r < PANEL_ROWS; r++) row_synced[r] = 1'b0;
      end
      default: begin
        emit(KIND_ACK, RS_CMD, 4'h0);
      end
    endcase
    // Mark the final result and release it
    staged_op.last = 1'b1;
    expected_bus_ops.push_back(staged_op);
    staged_valid = 1'b0;
  endfunction

  function automatic void push_op(logic [2:0] o, logic [1:0] r, logic [4:0] c, logic [7:0] ch);
    pending_ops.push_back('{op: o, row: r, col: c, ch: ch});
    ops_queued++;
  endfunction

  function automatic logic [4:0] pick_col();
    int width;
    width = eff_width();
    if (width > 0 && $urandom_range(99) < 85) return 5'($urandom_range(width - 1));
    return 5'($urandom_range(31));
  endfunction

  // Edge cases first: extremes, every operation, ignored writes, unchanged rows
  function automatic void queue_directed_ops();
    push_op(OP_FLUSH, 2'd0, 5'd0, 8'h00);
    push_op(OP_FLUSH, 2'd0, 5'd0, 8'h00);
    push_op(OP_CLEAR, 2'd0, 5'd0, 8'h00);
    push_op(OP_CLEAR, 2'd3, 5'd31, 8'hFF);
    push_op(OP_OFF, 2'd0, 5'd0, 8'h00);
    push_op(OP_OFF, 2'd0, 5'd0, 8'h00);
    push_op(OP_INIT, 2'd0, 5'd0, 8'h00);
    push_op(OP_WRITE, 2'd0, 5'd0, 8'h00);
    push_op(OP_WRITE, 2'd0, 5'd15, 8'hFF);
    push_op(OP_WRITE, 2'd0, 5'd16, 8'hA5);
    push_op(OP_WRITE, 2'd3, 5'd31, 8'h5A);
    push_op(OP_WRITE, 2'd1, 5'd19, 8'h7E);
    push_op(OP_FLUSH, 2'd0, 5'd0, 8'h00);
    push_op(OP_FLUSH, 2'd1, 5'd0, 8'h00);
    push_op(OP_FLUSH, 2'd2, 5'd0, 8'h00);
    push_op(OP_FLUSH, 2'd3, 5'd31, 8'hFF);
    push_op(OP_WRITE, 2'd1, 5'd5, SPACE_CHAR);
    push_op(OP_FLUSH, 2'd1, 5'd0, 8'h00);
    push_op(OP_RSVD_A, 2'd3, 5'd31, 8'hFF);
    push_op(OP_RSVD_B, 2'd1, 5'd10, 8'h55);
    push_op(OP_RSVD_C, 2'd2, 5'd21, 8'hAA);
    push_op(OP_WRITE, 2'd0, 5'd3, 8'hC3);
    push_op(OP_FLUSH, 2'd0, 5'd0, 8'h00);
  endfunction

  // Mostly fill-and-flush traffic, with stray operations mixed in
  function automatic void queue_random_ops(int count);
    int         n;
    int         pick;
    int         fill;
    logic [1:0] r;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      r = 2'($urandom_range(3));
      if (pick < 45) begin
        push_op(OP_WRITE, r, pick_col(), 8'($urandom_range(255)));
        n++;
      end else if (pick < 60) begin
        fill = $urandom_range(1, 4);
        for (int k = 0; k < fill; k++) push_op(OP_WRITE, r, pick_col(), 8'($urandom_range(255)));
        push_op(OP_FLUSH, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n += fill + 1;
        if ($urandom_range(1) == 1) begin
          push_op(OP_FLUSH, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
          n++;
        end
      end else if (pick < 78) begin
        push_op(OP_FLUSH, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n++;
      end else if (pick < 83) begin
        push_op(OP_CLEAR, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n++;
      end else if (pick < 88) begin
        push_op(OP_OFF, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n++;
      end else if (pick < 93) begin
        push_op(OP_INIT, r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n++;
      end else begin
        push_op(3'($urandom_range(7)), r, 5'($urandom_range(31)), 8'($urandom_range(255)));
        n++;
      end
    end
  endfunction

  // Register write in setup and access phases, mirrored into the panel image
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    int width;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COLUMNS: begin
        cfg_columns = value[4:0];
        width = eff_width();
        for (int r = 0; r < PANEL_ROWS; r++) begin
          row_synced[r] = 1'b0;
          for (int c = width; c < PANEL_COLS; c++) shadow_text[r][c] = SPACE_CHAR;
        end
      end
      REG_ROWS:      cfg_rows = value[2:0];
      REG_BACKLIGHT: cfg_bl_on = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    do @(posedge clk); while (ops_taken != ops_queued || expected_bus_ops.size() != 0);
  endtask

  // Feed items in bursts; predict each one as it is taken
  int      gap_left;
  int      burst_left;
  lcd_op_t next_op;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_lcd_ops({op, row, col, char_code});
        ops_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          op <= next_op.op;
          row <= next_op.row;
          col <= next_op.col;
          char_code <= next_op.ch;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output with a duty cycle that changes from stretch to stretch
  int span_left;
  int stall_pct;
  int stall_run;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      span_left = 0;
      stall_pct = 0;
      stall_run = 0;
    end else begin
      if (span_left == 0) begin
        span_left = $urandom_range(16, 200);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        span_left--;
      end
      if (stall_run >= MAX_STALL_RUN || $urandom_range(99) >= stall_pct) begin
        out_stall <= 1'b0;
        stall_run = 0;
      end else begin
        out_stall <= 1'b1;
        stall_run++;
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result taken against the oldest prediction
  bus_op_t want_op;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bus_ops.size() == 0) begin
        $error("result with nothing pending: kind %0h nibble %0h", kind, nibble);
        mismatches++;
      end else begin
        want_op = expected_bus_ops.pop_front();
        check_field("kind", want_op.kind, kind);
        check_field("reg_select", want_op.rs, reg_select);
        check_field("nibble", want_op.nib, nibble);
        check_field("backlight", want_op.bl, backlight);
        check_field("last", want_op.last, last);
      end
    end
  end

  // Abort when neither channel moves for too long
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** char_lcd_shadow_refresh: FAILED **");
      $finish;
    end
  end

  // Phases: register settings, then traffic, drained before the next write
  int cols_plan [PHASES]  = '{16, 20, 0, 31, 17, 5};
  int rows_plan [PHASES]  = '{2, 4, 4, 7, 0, 3};
  int level_plan [PHASES] = '{1, 0, 1, 0, 1, 0};

  initial begin
    ops_queued = 0;
    ops_taken = 0;
    mismatches = 0;
    reset_panel_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      reg_write(REG_COLUMNS, cols_plan[p]);
      reg_write(REG_ROWS, rows_plan[p]);
      reg_write(REG_BACKLIGHT, level_plan[p]);
      if (p == 0) queue_directed_ops();
      queue_random_ops(RANDOM_PER_PHASE);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bus_ops.size() == 0) begin
      $display("** char_lcd_shadow_refresh: PASSED **");
    end else begin
      $display("** char_lcd_shadow_refresh: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/clsr_pkg.sv
rtl/core/clsr_front.sv
rtl/core/clsr_queue.sv
rtl/core/clsr_back.sv
rtl/core/char_lcd_shadow_refresh.sv
tb/testbench.sv
